[rtl/plane_polygon_contact_resolver_defines.svh]
// Assertion macros shared by the wall contact RTL.
// Included by modules that carry concurrent checks.
`ifndef PLANE_POLYGON_CONTACT_RESOLVER_DEFINES_SVH
`define PLANE_POLYGON_CONTACT_RESOLVER_DEFINES_SVH
// implication checked every cycle outside reset
`define PPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define PPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

[rtl/ppc_pkg.sv]
// Package for the wall contact resolver: constants, types, rounding helpers.
// No dependencies.
`timescale 1ns / 1ps
package ppc_pkg;
  localparam int MaxVertices = 8;
  localparam int VidxW = $clog2(MaxVertices);
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int NrmFrac = 16;

  localparam logic [2:0] REG_REST = 3'd0;
  localparam logic [2:0] REG_NX = 3'd1;
  localparam logic [2:0] REG_NY = 3'd2;
  localparam logic [2:0] REG_NZ = 3'd3;
  localparam logic [2:0] REG_AX = 3'd4;
  localparam logic [2:0] REG_AY = 3'd5;
  localparam logic [2:0] REG_AZ = 3'd6;
  localparam logic [2:0] REG_VCNT = 3'd7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [17:0] nrm_t;

  // multiply-accumulate command to the shared unit
  typedef struct packed {
    logic               clr;
    logic               en;
    logic               neg;
    logic signed [51:0] a;
    logic signed [33:0] b;
  } mac_cmd_t;

  // round to nearest, ties up, after dropping NrmFrac bits
  function automatic logic signed [111:0] rnd16(input logic signed [111:0] v);
    logic signed [111:0] t;
    t = v + 112'sd32768;
    return t >>> NrmFrac;
  endfunction

  function automatic coord_t sat32(input logic signed [111:0] v);
    if (v > 112'sd2147483647) return 32'sh7fffffff;
    if (v < -112'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

[rtl/ppc_ram.sv]
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ppc_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/ppc_mac.sv]
// Shared multiply-accumulate unit: 52x34 product split into two 26-bit
// halves, accumulated into a 112-bit register. Uses ppc_pkg.
`timescale 1ns / 1ps
module ppc_mac (
  input  logic                     clk,
  input  logic                     rst,
  input  ppc_pkg::mac_cmd_t        cmd,
  output logic                     busy,
  output logic signed [111:0]      acc
);
  import ppc_pkg::*;
  logic               phase;
  logic               pend;
  logic               phase_run;
  logic signed [51:0] a_q;
  logic signed [33:0] b_q;
  logic               neg_q;
  logic signed [60:0] part;
  logic signed [111:0] ext;

  // low half unsigned, high half signed
  always_comb begin
    if (!phase) part = $signed({1'b0, a_q[25:0]}) * b_q;
    else part = $signed(a_q[51:26]) * b_q;
    ext = phase ? ({{51{part[60]}}, part} <<< 26) : {{51{part[60]}}, part};
    if (neg_q) ext = -ext;
  end

  // busy from the cycle after the command until both halves are in
  assign busy = pend | phase;
  assign phase_run = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      acc <= '0;
    end else begin
      if (cmd.clr) acc <= '0;
      if (cmd.en) begin
        a_q <= cmd.a;
        b_q <= cmd.b;
        neg_q <= cmd.neg;
        phase <= 1'b0;
      end
      if (phase_run) begin
        acc <= acc + ext;
        phase <= ~phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else if (cmd.en) pend <= 1'b1;
    else if (phase) pend <= 1'b0;
  end
endmodule

[rtl/plane_polygon_contact_resolver.sv]
// Wall contact resolver top level: registers, vertex RAM, sequencer.
// Uses ppc_pkg, ppc_ram, ppc_mac and the assertion header.
// A load word is written to the vertex RAM when accepted. A test word walks the
// edges (edges = vertex count capped at eight, 0 below two), then distance, vn, outputs.
// No new word until a test word finishes; result held until taken, in_ready low.
// Synchronous reset clears config registers and control; vertex RAM is not cleared.
`timescale 1ns / 1ps
`include "plane_polygon_contact_resolver_defines.svh"
module plane_polygon_contact_resolver (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [2:0]          vertex_index,
  input  ppc_pkg::coord_t     vertex_x,
  input  ppc_pkg::coord_t     vertex_y,
  input  ppc_pkg::coord_t     vertex_z,
  input  ppc_pkg::coord_t     pos_x,
  input  ppc_pkg::coord_t     pos_y,
  input  ppc_pkg::coord_t     pos_z,
  input  ppc_pkg::coord_t     vel_x,
  input  ppc_pkg::coord_t     vel_y,
  input  ppc_pkg::coord_t     vel_z,
  input  logic [30:0]         radius,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                on_polygon,
  output logic                in_contact,
  output ppc_pkg::coord_t     new_pos_x,
  output ppc_pkg::coord_t     new_pos_y,
  output ppc_pkg::coord_t     new_pos_z,
  output ppc_pkg::coord_t     new_vel_x,
  output ppc_pkg::coord_t     new_vel_y,
  output ppc_pkg::coord_t     new_vel_z
);
  import ppc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1; // RAM read of edge endpoints
  localparam logic [2:0] S_MAC  = 3'd2; // issue one product term
  localparam logic [2:0] S_WAIT = 3'd3; // let the MAC finish
  localparam logic [2:0] S_OUT  = 3'd4;

  // config registers
  logic [17:0] restitution;
  nrm_t        nrm [3];
  coord_t      anc [3];
  logic [3:0]  vertex_count;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= '0;
      nrm[0] <= '0; nrm[1] <= '0; nrm[2] <= '0;
      anc[0] <= '0; anc[1] <= '0; anc[2] <= '0;
      vertex_count <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REST: restitution <= cfg_data[17:0];
        REG_NX:   nrm[0] <= cfg_data[17:0];
        REG_NY:   nrm[1] <= cfg_data[17:0];
        REG_NZ:   nrm[2] <= cfg_data[17:0];
        REG_AX:   anc[0] <= cfg_data;
        REG_AY:   anc[1] <= cfg_data;
        REG_AZ:   anc[2] <= cfg_data;
        REG_VCNT: vertex_count <= cfg_data[3:0];
        default:  ;
      endcase
    end
  end

  // vertex table
  logic [2:0]  state;
  logic [95:0] rdata;
  logic [VidxW-1:0] raddr;
  logic        ld;
  assign ld = in_valid && in_ready && (op == OP_LOAD);
  ppc_ram #(.Width(96), .Depth(MaxVertices)) u_ram (
    .clk(clk), .we(ld), .waddr(vertex_index[VidxW-1:0]),
    .wdata({vertex_z, vertex_y, vertex_x}), .raddr(raddr), .rdata(rdata));

  // captured test word
  coord_t p [3];
  coord_t v [3];
  logic [30:0] rad;
  logic [CntW-1:0] n;
  logic [CntW-1:0] edge_i;
  logic [4:0] step;          // term counter within phase
  logic [1:0] phase;         // 0 edges, 1 distance, 2 vn, 3 outputs
  logic       rd_which;      // 0 reading from, 1 reading to
  logic signed [32:0] fr [3];
  logic signed [32:0] ea [3];
  logic signed [32:0] eb [3];
  logic       first_neg;
  logic       fail;
  logic signed [111:0] vn, wall_dist;
  logic signed [111:0] tmp;

  mac_cmd_t cmd;
  logic mbusy;
  logic signed [111:0] acc;
  ppc_mac u_mac (.clk(clk), .rst(rst), .cmd(cmd), .busy(mbusy), .acc(acc));

  // term selection
  logic signed [51:0] ta;
  logic signed [33:0] tb;
  logic tneg;
  logic [CntW-1:0] nxt_i;
  logic signed [18:0] factor;
  always_comb begin
    ta = '0; tb = '0; tneg = 1'b0;
    factor = $signed(19'sd131072 - $signed({1'b0, restitution}));
    case (phase)
      2'd0: begin
        // n.(a x b): terms k=0..5
        case (step[2:0])
          3'd0: begin ta = 52'(nrm[0] * ea[1]); tb = 34'(eb[2]); end
          3'd1: begin ta = 52'(nrm[0] * ea[2]); tb = 34'(eb[1]); tneg = 1'b1; end
          3'd2: begin ta = 52'(nrm[1] * ea[2]); tb = 34'(eb[0]); end
          3'd3: begin ta = 52'(nrm[1] * ea[0]); tb = 34'(eb[2]); tneg = 1'b1; end
          3'd4: begin ta = 52'(nrm[2] * ea[0]); tb = 34'(eb[1]); end
          default: begin ta = 52'(nrm[2] * ea[1]); tb = 34'(eb[0]); tneg = 1'b1; end
        endcase
      end
      2'd1: begin
        ta = 52'($signed({anc[step[1:0]][31], anc[step[1:0]]}) - p[step[1:0]]);
        tb = 34'(nrm[step[1:0]]);
      end
      2'd2: begin ta = 52'(v[step[1:0]]); tb = 34'(nrm[step[1:0]]); end
      default: begin
        // step 0..2: normal*radius; 3..5 normal*vn; 6..8 proj*factor
        if (step < 5'd3) begin
          ta = 52'($signed({1'b0, rad})); tb = 34'(nrm[step[1:0]]);
        end else if (step < 5'd6) begin
          ta = vn[51:0]; tb = 34'(nrm[2'(step - 5'd3)]);
        end else begin
          ta = tmp[51:0]; tb = 34'(factor);
        end
      end
    endcase
    nxt_i = (edge_i + 1'b1 == n) ? '0 : edge_i + 1'b1;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cmd <= '0;
    end else begin
      cmd <= '0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && op == OP_TEST) begin
            p[0] <= pos_x; p[1] <= pos_y; p[2] <= pos_z;
            v[0] <= vel_x; v[1] <= vel_y; v[2] <= vel_z;
            rad <= radius;
            n <= (vertex_count > 4'(MaxVertices)) ? CntW'(MaxVertices)
                                                  : CntW'(vertex_count);
            edge_i <= '0; step <= '0; fail <= 1'b0; rd_which <= 1'b0;
            raddr <= '0;
            phase <= (vertex_count < 4'd2) ? 2'd1 : 2'd0;
            cmd.clr <= 1'b1;
            state <= (vertex_count < 4'd2) ? S_MAC : S_RD;
          end
        end
        S_RD: begin
          // two reads: from-vertex then to-vertex
          if (!rd_which) begin
            raddr <= nxt_i[VidxW-1:0];
            rd_which <= 1'b1;
          end else begin
            fr[0] <= {rdata[31], rdata[31:0]};
            fr[1] <= {rdata[63], rdata[63:32]};
            fr[2] <= {rdata[95], rdata[95:64]};
            rd_which <= 1'b0;
            step <= 5'd31;
          end
          if (step == 5'd31) begin
            for (int k = 0; k < 3; k++) begin
              ea[k] <= $signed({p[k][31], p[k]}) - fr[k];
              eb[k] <= $signed({rdata[32*k+31], rdata[32*k +: 32]}) - fr[k];
            end
            rd_which <= 1'b0;
            step <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          cmd.en <= 1'b1; cmd.a <= ta; cmd.b <= tb; cmd.neg <= tneg;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (!cmd.en && !mbusy) begin
            state <= S_MAC;
            step <= step + 1'b1;
            unique case (phase)
              2'd0: if (step == 5'd5) begin
                if (edge_i == '0) first_neg <= acc[111];
                else if ((acc[111] && !first_neg) ||
                         (!acc[111] && acc != '0 && first_neg)) fail <= 1'b1;
                cmd.clr <= 1'b1;
                step <= '0;
                if (nxt_i == '0) phase <= 2'd1;
                else begin
                  edge_i <= nxt_i; raddr <= nxt_i[VidxW-1:0]; state <= S_RD;
                end
              end
              2'd1: if (step == 5'd2) begin
                wall_dist <= acc; cmd.clr <= 1'b1; step <= '0; phase <= 2'd2;
              end
              2'd2: if (step == 5'd2) begin
                vn <= rnd16(acc); cmd.clr <= 1'b1; step <= '0; phase <= 2'd3;
              end
              default: begin
                cmd.clr <= 1'b1;
                if (step < 5'd3) begin
                  unique case (step[1:0])
                    2'd0: new_pos_x <= sat32(112'(anc[0]) + rnd16(acc));
                    2'd1: new_pos_y <= sat32(112'(anc[1]) + rnd16(acc));
                    default: new_pos_z <= sat32(112'(anc[2]) + rnd16(acc));
                  endcase
                end else if (step < 5'd6) begin
                  tmp <= rnd16(acc);
                  step <= step + 5'd3;
                end else begin
                  unique case (step)
                    5'd6: new_vel_x <= sat32(112'(v[0]) - rnd16(acc));
                    5'd7: new_vel_y <= sat32(112'(v[1]) - rnd16(acc));
                    default: new_vel_z <= sat32(112'(v[2]) - rnd16(acc));
                  endcase
                  step <= step - 5'd2;
                  if (step == 5'd8) state <= S_OUT;
                end
              end
            endcase
          end
        end
        default: begin
          on_polygon <= !fail;
          in_contact <= !fail && (wall_dist > -$signed({1'b0, rad, 16'b0})) &&
                        (wall_dist < $signed({1'b0, rad, 16'b0}));
          out_valid <= 1'b1;
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  `PPC_ASSERT_IMP(a_busy_no_ready, state != S_IDLE, !in_ready)
  `PPC_ASSERT_IMP(a_out_in_out_state, out_valid, state == S_OUT)
  `PPC_ASSERT_NXT(a_take_leaves, out_valid && out_ready, state == S_IDLE)
endmodule

[bench/tb.sv]
// Self-checking bench for the wall contact resolver: vertex loads, particle tests.
// Depends on ppc_pkg and the plane_polygon_contact_resolver RTL.
`timescale 1ns / 1ps
module tb;
  import ppc_pkg::*;

  typedef struct {
    logic        op;
    logic [2:0]  vidx;
    logic signed [31:0] vx, vy, vz, px, py, pz, ux, uy, uz;
    logic [30:0] rad;
  } word_t;

  typedef struct {
    logic onp, cont;
    logic signed [31:0] npx, npy, npz, nvx, nvy, nvz;
  } resolved_t;

  logic clk = 1'b0, rst = 1'b1;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic op = 1'b0;
  logic [2:0] vertex_index = '0;
  coord_t vertex_x = '0, vertex_y = '0, vertex_z = '0;
  coord_t pos_x = '0, pos_y = '0, pos_z = '0, vel_x = '0, vel_y = '0, vel_z = '0;
  logic [30:0] radius = '0;
  logic out_valid, out_ready = 1'b0;
  logic on_polygon, in_contact;
  coord_t new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;

  plane_polygon_contact_resolver dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and vertex table
  logic [17:0] sh_rest;
  logic signed [17:0] sh_nrm [3];
  logic signed [31:0] sh_anc [3];
  logic [3:0] sh_vcnt;
  logic signed [31:0] sh_vtx [8][3];
  bit written [8];

  word_t pending_words [$];
  resolved_t expected_results [$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;   // percent
  bit hold_out = 1'b0;
  event hold_go;
  int cfg_pending = 0;                 // config writes in flight
  logic [2:0] cfg_q_idx [$];
  logic [31:0] cfg_q_dat [$];

  function automatic logic signed [127:0] rnd16(logic signed [127:0] v);
    return (v + 128'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // sign of n . ((P - from) x (to - from))
  function automatic int edge_side(logic signed [127:0] p[3], int fi, int ti);
    logic signed [127:0] a[3], b[3], n[3], acc;
    for (int k = 0; k < 3; k++) begin
      a[k] = p[k] - sh_vtx[fi][k];
      b[k] = 128'(sh_vtx[ti][k]) - sh_vtx[fi][k];
      n[k] = sh_nrm[k];
    end
    acc = n[0] * (a[1] * b[2] - a[2] * b[1]) + n[1] * (a[2] * b[0] - a[0] * b[2])
        + n[2] * (a[0] * b[1] - a[1] * b[0]);
    return (acc < 0) ? -1 : (acc == 0 ? 0 : 1);
  endfunction

  function automatic resolved_t resolve_particle(word_t w);
    resolved_t r;
    logic signed [127:0] p[3], v[3], d, vn, fac, rr, proj;
    int cnt, first, s, j;
    p[0] = w.px; p[1] = w.py; p[2] = w.pz;
    v[0] = w.ux; v[1] = w.uy; v[2] = w.uz;
    rr = {97'd0, w.rad};
    cnt = (sh_vcnt > 8) ? 8 : sh_vcnt;
    r.onp = 1'b1;
    if (cnt >= 2) begin
      first = edge_side(p, 0, 1);
      for (int i = 1; i < cnt; i++) begin
        j = (i + 1 == cnt) ? 0 : i + 1;
        s = edge_side(p, i, j);
        if ((s < 0 && first >= 0) || (s > 0 && first < 0)) r.onp = 1'b0;
      end
    end
    d = 0; vn = 0;
    for (int k = 0; k < 3; k++) begin
      d += (128'(sh_anc[k]) - p[k]) * sh_nrm[k];
      vn += v[k] * sh_nrm[k];
    end
    vn = rnd16(vn);
    r.cont = r.onp && (d > -(rr <<< 16)) && (d < (rr <<< 16));
    fac = (128'sd2 <<< 16) - $signed({110'd0, sh_rest});
    proj = rnd16(sh_nrm[0] * vn);
    r.npx = clamp32(sh_anc[0] + rnd16(sh_nrm[0] * rr));
    r.nvx = clamp32(v[0] - rnd16(proj * fac));
    proj = rnd16(sh_nrm[1] * vn);
    r.npy = clamp32(sh_anc[1] + rnd16(sh_nrm[1] * rr));
    r.nvy = clamp32(v[1] - rnd16(proj * fac));
    proj = rnd16(sh_nrm[2] * vn);
    r.npz = clamp32(sh_anc[2] + rnd16(sh_nrm[2] * rr));
    r.nvz = clamp32(v[2] - rnd16(proj * fac));
    return r;
  endfunction

  task automatic present(word_t w);
    in_valid <= 1'b1;
    op <= w.op; vertex_index <= w.vidx;
    vertex_x <= w.vx; vertex_y <= w.vy; vertex_z <= w.vz;
    pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
    vel_x <= w.ux; vel_y <= w.uy; vel_z <= w.uz;
    radius <= w.rad;
  endtask

  // input driver: one word offered at a time, held until accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          present(pending_words.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && pending_words.size() > 0
                   && $urandom_range(99) >= send_idle) begin
        present(pending_words.pop_front());
      end
    end
  end

  // predictor: tracks every accepted word
  always @(posedge clk) begin
    word_t w;
    if (!rst && in_valid && in_ready) begin
      w.op = op; w.vidx = vertex_index;
      w.vx = vertex_x; w.vy = vertex_y; w.vz = vertex_z;
      w.px = pos_x; w.py = pos_y; w.pz = pos_z;
      w.ux = vel_x; w.uy = vel_y; w.uz = vel_z; w.rad = radius;
      if (w.op == OP_LOAD) begin
        sh_vtx[w.vidx][0] = w.vx; sh_vtx[w.vidx][1] = w.vy; sh_vtx[w.vidx][2] = w.vz;
      end else begin
        expected_results.push_back(resolve_particle(w));
      end
    end
  end

  // config driver and shadow update
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REST: sh_rest = cfg_data[17:0];
          REG_NX:   sh_nrm[0] = cfg_data[17:0];
          REG_NY:   sh_nrm[1] = cfg_data[17:0];
          REG_NZ:   sh_nrm[2] = cfg_data[17:0];
          REG_AX:   sh_anc[0] = cfg_data;
          REG_AY:   sh_anc[1] = cfg_data;
          REG_AZ:   sh_anc[2] = cfg_data;
          REG_VCNT: sh_vcnt = cfg_data[3:0];
          default: ;
        endcase
        cfg_pending--;
      end
      if ((!cfg_valid || cfg_ready) && cfg_q_idx.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_q_idx.pop_front();
        cfg_data <= cfg_q_dat.pop_front();
      end else if (cfg_valid && cfg_ready) begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here on request
  always begin
    @(hold_go);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
  end

  // receiver: random stalls plus a forced hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_out && ($urandom_range(99) >= recv_stall);
  end

  // result monitor
  always @(posedge clk) begin
    resolved_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (on_polygon !== e.onp) begin
          $error("on_polygon exp %0d got %0d", e.onp, on_polygon); errors++;
        end
        if (in_contact !== e.cont) begin
          $error("in_contact exp %0d got %0d", e.cont, in_contact); errors++;
        end
        if (new_pos_x !== e.npx) begin
          $error("new_pos_x exp %0d got %0d", e.npx, new_pos_x); errors++;
        end
        if (new_pos_y !== e.npy) begin
          $error("new_pos_y exp %0d got %0d", e.npy, new_pos_y); errors++;
        end
        if (new_pos_z !== e.npz) begin
          $error("new_pos_z exp %0d got %0d", e.npz, new_pos_z); errors++;
        end
        if (new_vel_x !== e.nvx) begin
          $error("new_vel_x exp %0d got %0d", e.nvx, new_vel_x); errors++;
        end
        if (new_vel_y !== e.nvy) begin
          $error("new_vel_y exp %0d got %0d", e.nvy, new_vel_y); errors++;
        end
        if (new_vel_z !== e.nvz) begin
          $error("new_vel_z exp %0d got %0d", e.nvz, new_vel_z); errors++;
        end
      end
    end
  end

  // watchdog: a test word in flight and a receiver stall both delay the next handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready) || hold_out) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return ($signed($urandom_range(40)) - 20) <<< 16;
    endcase
  endfunction

  function automatic word_t vertex_word(logic [2:0] idx,
                                       logic signed [31:0] x, y, z);
    word_t w;
    w = '{default: '0};
    w.op = OP_LOAD; w.vidx = idx; w.vx = x; w.vy = y; w.vz = z;
    w.px = $urandom; w.ux = $urandom; w.rad = 31'($urandom);
    written[idx] = 1'b1;
    return w;
  endfunction

  function automatic word_t particle_word();
    word_t w;
    w.op = OP_TEST; w.vidx = 3'($urandom);
    w.vx = $urandom; w.vy = $urandom; w.vz = $urandom;
    w.px = rand_coord(); w.py = rand_coord(); w.pz = rand_coord();
    w.ux = rand_coord(); w.uy = rand_coord(); w.uz = rand_coord();
    case ($urandom_range(3))
      0: w.rad = 31'($urandom);
      1: w.rad = $urandom_range(1) ? 31'h7fffffff : 31'd0;
      default: w.rad = 31'($urandom_range(30) << 16);
    endcase
    return w;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_q_idx.push_back(idx);
    cfg_q_dat.push_back(val);
    cfg_pending++;
  endtask

  // checked at the falling edge, when all driver updates have settled
  task automatic drain();
    @(negedge clk);
    while (!(pending_words.size() == 0 && !in_valid && expected_results.size() == 0
             && cfg_pending == 0)) @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  // square of side 2*s in the plane z=0, CCW or CW
  task automatic load_square(int s, bit cw);
    logic signed [31:0] q;
    q = s <<< 16;
    pending_words.push_back(vertex_word(3'd0, -q, -q, 0));
    pending_words.push_back(vertex_word(cw ? 3'd3 : 3'd1, q, -q, 0));
    pending_words.push_back(vertex_word(3'd2, q, q, 0));
    pending_words.push_back(vertex_word(cw ? 3'd1 : 3'd3, -q, q, 0));
  endtask

  task automatic setup_wall(logic [31:0] rest, nx, ny, nz, ax, ay, az, cnt);
    write_reg(REG_REST, rest);
    write_reg(REG_NX, nx); write_reg(REG_NY, ny); write_reg(REG_NZ, nz);
    write_reg(REG_AX, ax); write_reg(REG_AY, ay); write_reg(REG_AZ, az);
    write_reg(REG_VCNT, cnt);
    wait (cfg_pending == 0);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_nrm();
    case ($urandom_range(3))
      0: return 32'h10000;
      1: return 32'(-18'sd65536);
      2: return 32'(18'($urandom));
      default: return 32'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // vertex count only ever covers loaded slots
  function automatic logic [31:0] safe_count();
    int c;
    c = 0;
    while (c < 8 && written[c]) c++;
    if (c < 2) return $urandom_range(1);
    return $urandom_range(1) ? 32'(c) : 32'($urandom_range(c));
  endfunction

  int phase_idle[4] = '{0, 72, 0, 22};
  int phase_stall[4] = '{0, 0, 72, 22};
  word_t w;

  initial begin
    sh_rest = 0; sh_vcnt = 0;
    for (int k = 0; k < 3; k++) begin sh_nrm[k] = 0; sh_anc[k] = 0; end
    for (int i = 0; i < 8; i++) written[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: infinite wall at reset, then z-normal square wall
    for (int i = 0; i < 2; i++) pending_words.push_back(particle_word());
    drain();
    setup_wall(32'h10000, 0, 0, 32'h10000, 0, 0, 0, 4);
    load_square(4, 0);
    w = particle_word(); w.px = 0; w.py = 0; w.pz = 1 <<< 16; w.rad = 31'(2 <<< 16);
    pending_words.push_back(w);                  // inside, touching
    w.px = 10 <<< 16;
    pending_words.push_back(w);                  // outside polygon
    w.px = 4 <<< 16; w.pz = 2 <<< 16;
    pending_words.push_back(w);                  // on edge, exactly at radius
    w.px = 32'sh7fffffff; w.py = 32'sh80000000; w.ux = 32'sh7fffffff;
    w.uz = 32'sh80000000; w.rad = 31'h7fffffff;
    pending_words.push_back(w);                  // extremes, saturation
    pending_words.push_back(particle_word());
    drain();
    load_square(4, 1);                           // clockwise winding
    w = particle_word(); w.px = 1 <<< 16; w.py = 0; w.pz = 0;
    pending_words.push_back(w);
    w.py = 9 <<< 16;
    pending_words.push_back(w);
    drain();
    // restitution two and above two, negative normal, oversize count
    for (int i = 4; i < 8; i++)
      pending_words.push_back(vertex_word(i[2:0], rand_coord(), rand_coord(), 0));
    drain();
    setup_wall(32'h3ffff, 32'(-18'sd65536), 32'h1ffff, 32'h20000,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 15);
    for (int i = 0; i < 4; i++) pending_words.push_back(particle_word());
    drain();
    setup_wall(32'h20000, 0, 32'h10000, 0, 0, 0, 0, 8);
    for (int i = 0; i < 3; i++) pending_words.push_back(particle_word());
    drain();

    // random phases, each with its own wall setting
    for (int ph = 0; ph < 8; ph++) begin
      send_idle = phase_idle[ph % 4];
      recv_stall = phase_stall[ph % 4];
      setup_wall($urandom_range(3) == 0 ? $urandom : $urandom_range(131072),
                 rand_nrm(), rand_nrm(), rand_nrm(),
                 rand_coord(), rand_coord(), rand_coord(), safe_count());
      for (int i = 0; i < 52; i++) begin
        if ($urandom_range(5) == 0)
          pending_words.push_back(vertex_word(3'($urandom), rand_coord(), rand_coord(),
                                              rand_coord()));
        else pending_words.push_back(particle_word());
        if (ph == 2 && i == 20) begin
          // long receiver hold-off while words keep coming
          -> hold_go;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[plane_polygon_contact_resolver.f]
+incdir+rtl
rtl/ppc_pkg.sv
rtl/ppc_ram.sv
rtl/ppc_mac.sv
rtl/plane_polygon_contact_resolver.sv
bench/tb.sv
